[rtl/core/point_segment_distance_top_defines.svh]
// ----------------------------------------------------------------------------
// Point segment distance assertion macros
// Concurrent check wrappers sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("point_segment_distance check failed");
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_segment_distance check failed");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/psd_pkg.sv]
// ----------------------------------------------------------------------------
// Point segment distance package
// Shared widths for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int COORD_W_DEF = 16;
  localparam int DIST_W      = 17;
endpackage

[rtl/core/point_segment_distance_top.sv]
// ----------------------------------------------------------------------------
// Point segment distance
// Perpendicular distance from a point to a 2D segment, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters per cycle unless an output stall has filled the pipeline;
// four stages form the differences, the products, the dot, cross and
// squared length, and the squared cross product; then one stage per result
// bit (COORD_WIDTH + 1 of them) runs a shift-and-subtract search for the
// largest q with q*q*len2 <= cross*cross. Every stage holds its item while
// the stage after it is full and held, so empty stages still fill during an
// output stall. Items off the segment or with a zero-length segment give
// distance 0 and inside_res 0.
`include "point_segment_distance_top_defines.svh"

module point_segment_distance_top
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DIST_W-1:0]             distance,
  output logic                          inside_res
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int LW = SW - 1;
  localparam int CW = 4 * COORD_WIDTH + 6;
  localparam int QW = COORD_WIDTH + 1;
  localparam int NS = 4 + QW;

  logic v  [NS];
  logic en [NS];

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        v[i] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // differences against segment begin
  logic signed [DW-1:0] px, py, dx, dy;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px <= DW'(point_x) - DW'(start_x);
      py <= DW'(point_y) - DW'(start_y);
      dx <= DW'(end_x) - DW'(start_x);
      dy <= DW'(end_y) - DW'(start_y);
    end
  end

  // products
  logic signed [PW-1:0] m_pxdx, m_pydy, m_dxdx, m_dydy, m_pxdy, m_pydx;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_pxdx <= px * dx;
      m_pydy <= py * dy;
      m_dxdx <= dx * dx;
      m_dydy <= dy * dy;
      m_pxdy <= px * dy;
      m_pydx <= py * dx;
    end
  end

  // dot, squared length, cross
  logic signed [SW-1:0] dot_c, len2_c, cross_c, slack_c;
  logic [LW-1:0]        len2_r, acr_r;
  logic                 ins_r;

  always_comb begin
    dot_c   = SW'(m_pxdx) + SW'(m_pydy);
    len2_c  = SW'(m_dxdx) + SW'(m_dydy);
    cross_c = SW'(m_pxdy) - SW'(m_pydx);
    slack_c = len2_c - dot_c;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ins_r  <= (len2_c != '0) && !dot_c[SW-1] && !slack_c[SW-1];
      len2_r <= len2_c[LW-1:0];
      acr_r  <= cross_c[SW-1] ? LW'(-cross_c) : cross_c[LW-1:0];
    end
  end

  // search state: remainder, q*len2, q
  logic [CW-1:0] rr [QW+1];
  logic [CW-1:0] tt [QW+1];
  logic [CW-1:0] ll [QW+1];
  logic [QW-1:0] qq [QW+1];
  logic          ins [QW+1];
  logic [2*LW-1:0] sq_c;

  assign sq_c = acr_r * acr_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rr[0]  <= CW'(sq_c);
      tt[0]  <= '0;
      ll[0]  <= CW'(len2_r);
      qq[0]  <= '0;
      ins[0] <= ins_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int B = QW - 1 - j;
    logic [CW-1:0] inc;
    logic          take;

    always_comb begin
      inc  = (tt[j] << (B + 1)) + (ll[j] << (2 * B));
      take = inc <= rr[j];
    end

    always_ff @(posedge clk) begin
      if (en[4+j]) begin
        ll[j+1]  <= ll[j];
        ins[j+1] <= ins[j];
        if (take) begin
          rr[j+1] <= rr[j] - inc;
          tt[j+1] <= tt[j] + (ll[j] << B);
          qq[j+1] <= qq[j] | (QW'(1) << B);
        end else begin
          rr[j+1] <= rr[j];
          tt[j+1] <= tt[j];
          qq[j+1] <= qq[j];
        end
      end
    end
  end

  logic [QW+DIST_W-1:0] q_ext;

  assign q_ext      = {{DIST_W{1'b0}}, qq[QW]};
  assign out_valid  = v[NS-1];
  assign inside_res = ins[QW];
  assign distance   = ins[QW] ? q_ext[DIST_W-1:0] : '0;

  `PSD_ASSERT(a_zero_outside, !(out_valid && !inside_res) || (distance == '0))
  `PSD_ASSERT(a_ready_empty, v[0] || in_ready)
  `PSD_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid)
  `PSD_ASSERT_NEXT(a_fill_on_stall, in_valid && in_ready, v[0])

endmodule
